// ----- design/b2da_pkg.sv -----
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int WORD_W  = 32;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  // Reciprocal of ten: floor(x * RECIP_10 / 2^RECIP_SHIFT) == x / 10 for 32-bit x
  localparam logic [WORD_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                RECIP_SHIFT = 35;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

endpackage

// ----- design/b2da_div_stage.sv -----
// ----------------------------------------------------------------------------
// b2da_div_stage
// One pipeline stage: divide the running magnitude by ten, store the
// remainder as decimal digit INDEX and track the highest nonzero digit.
// ----------------------------------------------------------------------------
module b2da_div_stage #(
  parameter int DIGITS = 10,
  parameter int INDEX  = 0,
  parameter int TOP_W  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [b2da_pkg::WORD_W-1:0]         in_mag,
  input  logic                                in_neg,
  input  b2da_pkg::digit_t [DIGITS-1:0]       in_digits,
  input  logic [TOP_W-1:0]                    in_top,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b2da_pkg::WORD_W-1:0]         out_mag,
  output logic                                out_neg,
  output b2da_pkg::digit_t [DIGITS-1:0]       out_digits,
  output logic [TOP_W-1:0]                    out_top
);
  import b2da_pkg::*;

  logic [2*WORD_W-1:0]    prod;
  logic [WORD_W-1:0]      quot;
  logic [WORD_W-1:0]      quot_x10;
  logic [WORD_W-1:0]      rem_full;
  digit_t                 rem;
  digit_t [DIGITS-1:0]    digits_next;
  logic [TOP_W-1:0]       top_next;

  // Divide by ten through the reciprocal, remainder by multiply-back
  assign prod     = (2*WORD_W)'(in_mag) * (2*WORD_W)'(RECIP_10);
  assign quot     = WORD_W'(prod >> RECIP_SHIFT);
  assign quot_x10 = WORD_W'({quot, 3'b000}) + WORD_W'({quot, 1'b0});
  assign rem_full = in_mag - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];

  // Insert this digit, raise the top mark when it is nonzero
  always_comb begin
    digits_next        = in_digits;
    digits_next[INDEX] = rem;
    top_next           = (rem != '0) ? TOP_W'(INDEX) : in_top;
  end

  assign in_ready = !out_valid || out_ready;

  // Advance the valid bit when the next stage can take the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load the payload with the beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_mag    <= quot;
      out_neg    <= in_neg;
      out_digits <= digits_next;
      out_top    <= top_next;
    end
  end

endmodule

// ----- design/b2da_serializer.sv -----
// ----------------------------------------------------------------------------
// b2da_serializer
// Output stage: hold one converted number and send its text one character
// per beat, sign first, then digits from the highest nonzero one down.
// ----------------------------------------------------------------------------
module b2da_serializer #(
  parameter int DIGITS = 10,
  parameter int TOP_W  = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_neg,
  input  b2da_pkg::digit_t [DIGITS-1:0]  in_digits,
  input  logic [TOP_W-1:0]               in_top,
  output logic                           char_valid,
  input  logic                           char_ready,
  output b2da_pkg::char_t                text_char,
  output logic                           last_char
);
  import b2da_pkg::*;

  logic                 busy;
  logic                 show_sign;
  logic [TOP_W-1:0]     pos;
  digit_t [DIGITS-1:0]  dig;
  logic                 char_fire;
  logic                 load;

  assign char_valid = busy;
  assign text_char  = show_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(dig[pos]));
  assign last_char  = !show_sign && (pos == '0);
  assign char_fire  = busy && char_ready;
  assign in_ready   = !busy || (char_ready && last_char);
  assign load       = in_valid && in_ready;

  // Step through the characters; reload right after the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      show_sign <= 1'b0;
    end else if (load) begin
      busy      <= 1'b1;
      show_sign <= in_neg;
    end else if (char_fire) begin
      if (show_sign) begin
        show_sign <= 1'b0;
      end else if (pos == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // Hold the digits and the position of the next digit to send
  always_ff @(posedge clk) begin
    if (load) begin
      dig <= in_digits;
      pos <= in_top;
    end else if (char_fire && !show_sign && (pos != '0)) begin
      pos <= pos - TOP_W'(1);
    end
  end

  a_sign_needs_busy : assert property (@(posedge clk) disable iff (rst)
    show_sign |-> busy)
    else $error("sign pending while serializer idle");

  a_digit_range : assert property (@(posedge clk) disable iff (rst)
    (busy && !show_sign) |-> (dig[pos] <= 4'd9))
    else $error("decimal digit out of range");

  a_drain_idle : assert property (@(posedge clk) disable iff (rst)
    (char_fire && last_char && !in_valid) |=> !busy)
    else $error("serializer stayed busy after final character");

  a_mid_busy : assert property (@(posedge clk) disable iff (rst)
    (char_fire && !last_char) |=> busy)
    else $error("serializer dropped a number before its final character");

endmodule

// ----- design/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts a 32-bit word, read as signed or unsigned, into its decimal text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_ready carries word_value and signed_mode.
//   Output channel char_valid/char_ready carries one ASCII character per beat
//   in text_char, most significant first; last_char marks the final one.
//   A negative signed word starts with '-'; zero gives a single '0'.
//   Only the low DIGITS decimal digits of the magnitude are kept.
// Path: an input beat passes one input register, DIGITS divide-by-ten
//   stages, then the output serializer that sends its first character.
// Throughput: while char_ready is high the serializer sends one character
//   per cycle and reloads in the cycle of a number's final character, so a
//   number of n characters (1 to 11) occupies the output until all n are
//   sent; input beats are taken at that pace once the pipeline has filled,
//   and at one per cycle until then.
// Reset: clears all valid bits; the pipeline and output come up empty.
// Stall: when char_ready is low the serializer holds its character and the
//   pipeline stages fill up behind it, then item_ready drops; nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
  parameter int DIGITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [b2da_pkg::WORD_W-1:0] word_value,
  input  logic                        signed_mode,
  output logic                        char_valid,
  input  logic                        char_ready,
  output b2da_pkg::char_t             text_char,
  output logic                        last_char
);
  import b2da_pkg::*;

  localparam int TOP_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                 st_valid  [DIGITS+1];
  logic                 st_ready  [DIGITS+1];
  logic [WORD_W-1:0]    st_mag    [DIGITS+1];
  logic                 st_neg    [DIGITS+1];
  digit_t [DIGITS-1:0]  st_digits [DIGITS+1];
  logic [TOP_W-1:0]     st_top    [DIGITS+1];

  logic                 negative;
  logic                 head_valid;
  logic [WORD_W-1:0]    head_mag;
  logic                 head_neg;

  // Form sign and magnitude in the input register
  assign negative   = signed_mode && word_value[WORD_W-1];
  assign item_ready = !head_valid || st_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (item_ready) begin
      head_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      head_neg <= negative;
      head_mag <= negative ? (WORD_W'(0) - word_value) : word_value;
    end
  end

  assign st_valid[0]  = head_valid;
  assign st_mag[0]    = head_mag;
  assign st_neg[0]    = head_neg;
  assign st_digits[0] = '0;
  assign st_top[0]    = '0;

  // Extract one decimal digit per stage, least significant first
  for (genvar k = 0; k < DIGITS; k++) begin : g_div
    b2da_div_stage #(
      .DIGITS (DIGITS),
      .INDEX  (k),
      .TOP_W  (TOP_W)
    ) u_div (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (st_valid[k]),
      .in_ready   (st_ready[k]),
      .in_mag     (st_mag[k]),
      .in_neg     (st_neg[k]),
      .in_digits  (st_digits[k]),
      .in_top     (st_top[k]),
      .out_valid  (st_valid[k+1]),
      .out_ready  (st_ready[k+1]),
      .out_mag    (st_mag[k+1]),
      .out_neg    (st_neg[k+1]),
      .out_digits (st_digits[k+1]),
      .out_top    (st_top[k+1])
    );
  end

  // Send the text one character per beat
  b2da_serializer #(
    .DIGITS (DIGITS),
    .TOP_W  (TOP_W)
  ) u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid[DIGITS]),
    .in_ready   (st_ready[DIGITS]),
    .in_neg     (st_neg[DIGITS]),
    .in_digits  (st_digits[DIGITS]),
    .in_top     (st_top[DIGITS]),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .text_char  (text_char),
    .last_char  (last_char)
  );

endmodule
